### rtl/cau_pkg.sv
// Types, codes and saturation helpers shared by the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

  localparam int DATA_W = 32;
  localparam int WIDE_W = 2 * DATA_W + 1;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_NEG  = 3'd5,
    OP_MAG  = 3'd6,
    OP_NONE = 3'd7
  } op_e;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
  localparam logic [DATA_W:0] Q_HALF = {2'b01, {(DATA_W - 1){1'b0}}};

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_re;
    logic signed [DATA_W-1:0] res_im;
    logic [1:0]               status;
  } rsp_t;

  typedef struct packed {
    logic                     flag;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  typedef struct packed {
    logic is_div;
    logic neg_re;
    logic neg_im;
    logic ovf_re;
    logic ovf_im;
    rsp_t res;
  } meta_t;

  function automatic logic signed [WIDE_W-1:0] ext(input logic signed [DATA_W-1:0] v);
    ext = {{(WIDE_W - DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic signed [WIDE_W-1:0] ext_prod(
      input logic signed [2*DATA_W-1:0] v);
    ext_prod = {v[2*DATA_W-1], v};
  endfunction

  function automatic sat_t sat_wide(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-DATA_W:0] hi;
    sat_t s;
    hi = v[WIDE_W-1:DATA_W-1];
    if (hi == '0 || hi == '1) begin
      s.flag = 1'b0;
      s.val  = v[DATA_W-1:0];
    end else begin
      s.flag = 1'b1;
      s.val  = v[WIDE_W-1] ? VAL_MIN : VAL_MAX;
    end
    sat_wide = s;
  endfunction

  function automatic sat_t sat_quot(input logic [DATA_W:0] q, input logic neg,
                                    input logic ovf);
    sat_t s;
    s.flag = 1'b0;
    s.val  = q[DATA_W-1:0];
    if (ovf) begin
      s.flag = 1'b1;
      s.val  = neg ? VAL_MIN : VAL_MAX;
    end else if (neg) begin
      if (q > Q_HALF) begin
        s.flag = 1'b1;
        s.val  = VAL_MIN;
      end else begin
        s.val = -q[DATA_W-1:0];
      end
    end else if (q >= Q_HALF) begin
      s.flag = 1'b1;
      s.val  = VAL_MAX;
    end
    sat_quot = s;
  endfunction

endpackage

### rtl/cau_div_stage.sv
// One restoring step of the two-lane quotient pipeline, with its stage register.
`timescale 1ns / 1ps
module cau_div_stage #(
  parameter int CW    = 98,
  parameter int DW    = 65,
  parameter int QW    = 33,
  parameter int SHIFT = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  cau_pkg::meta_t  in_meta,
  input  logic [DW-1:0]   in_d,
  input  logic [CW-1:0]   in_rem_re,
  input  logic [CW-1:0]   in_rem_im,
  input  logic [QW-1:0]   in_q_re,
  input  logic [QW-1:0]   in_q_im,
  output logic            out_valid,
  output cau_pkg::meta_t  out_meta,
  output logic [DW-1:0]   out_d,
  output logic [CW-1:0]   out_rem_re,
  output logic [CW-1:0]   out_rem_im,
  output logic [QW-1:0]   out_q_re,
  output logic [QW-1:0]   out_q_im
);

  logic [CW-1:0] dsh;
  logic          ge_re;
  logic          ge_im;
  logic [CW-1:0] rem_re_next;
  logic [CW-1:0] rem_im_next;
  logic [QW-1:0] q_re_next;
  logic [QW-1:0] q_im_next;

  always_comb begin
    dsh         = CW'(in_d) << SHIFT;
    ge_re       = in_rem_re >= dsh;
    ge_im       = in_rem_im >= dsh;
    rem_re_next = ge_re ? in_rem_re - dsh : in_rem_re;
    rem_im_next = ge_im ? in_rem_im - dsh : in_rem_im;
    q_re_next   = in_q_re | (QW'(ge_re) << SHIFT);
    q_im_next   = in_q_im | (QW'(ge_im) << SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_meta   <= in_meta;
      out_d      <= in_d;
      out_rem_re <= rem_re_next;
      out_rem_im <= rem_im_next;
      out_q_re   <= q_re_next;
      out_q_im   <= q_im_next;
    end
  end

endmodule

### rtl/complex_arithmetic_unit.sv
// Pipelined complex arithmetic unit on signed fixed-point operands.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_ready | cau_pkg::req_t
//   rsp     | out       | rsp_valid, rsp_ready | cau_pkg::rsp_t
//
// Every operation takes the same path from request to result.
// A new request enters every cycle unless rsp stalls; the depth is set by the
// quotient pipeline, one quotient bit per stage over DATA_W + 1 stages.
// Reset clears all valid bits; payload registers are not reset.
// Each stage holds while the stage after it is full and stalled; empty stages fill.
`timescale 1ns / 1ps
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  cau_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output cau_pkg::rsp_t  rsp
);

  localparam int W    = cau_pkg::DATA_W;
  localparam int WW   = cau_pkg::WIDE_W;
  localparam int CW   = 3 * W + FRAC_BITS + 2;
  localparam int NDIV = W + 1;

  // stage 1: products and short operations
  logic                    v1;
  cau_pkg::op_e            op1;
  logic signed [2*W-1:0]   pa, pb, pc, pd, pe, pf;
  cau_pkg::rsp_t           res1;
  logic                    dz1;
  logic                    r1;

  cau_pkg::op_e            op_in;
  logic signed [W-1:0]     x_re, x_im;
  cau_pkg::sat_t           s_re, s_im;
  cau_pkg::rsp_t           res1_next;

  always_comb begin
    op_in = cau_pkg::op_e'(req.operation);
    x_re  = (op_in == cau_pkg::OP_MAG) ? req.a_re : req.b_re;
    x_im  = (op_in == cau_pkg::OP_MAG) ? req.a_im : req.b_im;
    s_re  = '0;
    s_im  = '0;
    case (op_in)
      cau_pkg::OP_ADD: begin
        s_re = cau_pkg::sat_wide(cau_pkg::ext(req.a_re) + cau_pkg::ext(req.b_re));
        s_im = cau_pkg::sat_wide(cau_pkg::ext(req.a_im) + cau_pkg::ext(req.b_im));
      end
      cau_pkg::OP_SUB: begin
        s_re = cau_pkg::sat_wide(cau_pkg::ext(req.a_re) - cau_pkg::ext(req.b_re));
        s_im = cau_pkg::sat_wide(cau_pkg::ext(req.a_im) - cau_pkg::ext(req.b_im));
      end
      cau_pkg::OP_CONJ: begin
        s_re = cau_pkg::sat_wide(cau_pkg::ext(req.a_re));
        s_im = cau_pkg::sat_wide(-cau_pkg::ext(req.a_im));
      end
      cau_pkg::OP_NEG: begin
        s_re = cau_pkg::sat_wide(-cau_pkg::ext(req.a_re));
        s_im = cau_pkg::sat_wide(-cau_pkg::ext(req.a_im));
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
    res1_next.res_re = s_re.val;
    res1_next.res_im = s_im.val;
    res1_next.status = (s_re.flag || s_im.flag) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      op1  <= op_in;
      pa   <= req.a_re * req.b_re;
      pb   <= req.a_im * req.b_im;
      pc   <= req.a_re * req.b_im;
      pd   <= req.a_im * req.b_re;
      pe   <= x_re * x_re;
      pf   <= x_im * x_im;
      res1 <= res1_next;
      dz1  <= (op_in == cau_pkg::OP_DIV) && (req.b_re == '0) && (req.b_im == '0);
    end
  end

  // stage 2: sums of products
  logic                  v2;
  cau_pkg::op_e          op2;
  logic signed [WW-1:0]  x2, y2;
  logic [WW-1:0]         den2;
  cau_pkg::rsp_t         res2;
  logic                  dz2;
  logic                  r2;
  logic signed [WW-1:0]  x2_next, y2_next;

  always_comb begin
    case (op1)
      cau_pkg::OP_MUL: begin
        x2_next = cau_pkg::ext_prod(pa) - cau_pkg::ext_prod(pb);
        y2_next = cau_pkg::ext_prod(pc) + cau_pkg::ext_prod(pd);
      end
      cau_pkg::OP_DIV: begin
        x2_next = cau_pkg::ext_prod(pa) + cau_pkg::ext_prod(pb);
        y2_next = cau_pkg::ext_prod(pd) - cau_pkg::ext_prod(pc);
      end
      default: begin
        x2_next = cau_pkg::ext_prod(pe) + cau_pkg::ext_prod(pf);
        y2_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      op2  <= op1;
      x2   <= x2_next;
      y2   <= y2_next;
      den2 <= unsigned'(cau_pkg::ext_prod(pe) + cau_pkg::ext_prod(pf));
      res2 <= res1;
      dz2  <= dz1;
    end
  end

  // stage 3: scale products, set up the quotient
  logic                  v3;
  cau_pkg::meta_t        m3;
  logic [WW-1:0]         d3;
  logic [CW-1:0]         rem3_re, rem3_im;
  logic                  r3;
  cau_pkg::meta_t        m3_next;
  cau_pkg::sat_t         t_re, t_im;
  logic [WW-1:0]         abs_re, abs_im;

  always_comb begin
    t_re   = cau_pkg::sat_wide(x2 >>> FRAC_BITS);
    t_im   = cau_pkg::sat_wide(y2 >>> FRAC_BITS);
    abs_re = x2[WW-1] ? unsigned'(-x2) : unsigned'(x2);
    abs_im = y2[WW-1] ? unsigned'(-y2) : unsigned'(y2);
    m3_next        = '0;
    m3_next.res    = res2;
    m3_next.neg_re = x2[WW-1];
    m3_next.neg_im = y2[WW-1];
    case (op2)
      cau_pkg::OP_MUL: begin
        m3_next.res.res_re = t_re.val;
        m3_next.res.res_im = t_im.val;
        m3_next.res.status = (t_re.flag || t_im.flag) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::OP_MAG: begin
        m3_next.res.res_re = t_re.val;
        m3_next.res.res_im = '0;
        m3_next.res.status = t_re.flag ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::OP_DIV: begin
        m3_next.is_div     = !dz2;
        m3_next.res.res_re = '0;
        m3_next.res.res_im = '0;
        m3_next.res.status = cau_pkg::ST_DZ;
      end
      default: begin
        m3_next.res = res2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      m3      <= m3_next;
      d3      <= den2;
      rem3_re <= CW'(abs_re) << FRAC_BITS;
      rem3_im <= CW'(abs_im) << FRAC_BITS;
    end
  end

  // stage 4: quotient range check
  logic                  v4;
  cau_pkg::meta_t        m4;
  logic [WW-1:0]         d4;
  logic [CW-1:0]         rem4_re, rem4_im;
  logic                  r4;
  logic [CW-1:0]         dtop;
  cau_pkg::meta_t        m4_next;

  always_comb begin
    dtop           = CW'(d3) << (W + 1);
    m4_next        = m3;
    m4_next.ovf_re = rem3_re >= dtop;
    m4_next.ovf_im = rem3_im >= dtop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (r4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      m4        <= m4_next;
      d4        <= d3;
      rem4_re   <= rem3_re;
      rem4_im   <= rem3_im;
    end
  end

  // quotient pipeline, one bit per stage
  logic                  dv  [NDIV];
  cau_pkg::meta_t        dm  [NDIV];
  logic [WW-1:0]         dd  [NDIV];
  logic [CW-1:0]         drr [NDIV];
  logic [CW-1:0]         dri [NDIV];
  logic [W:0]            dqr [NDIV];
  logic [W:0]            dqi [NDIV];
  logic [NDIV-1:0]       dr;
  logic [NDIV-1:0]       dr_up;
  logic                  ro;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    if (k == 0) begin : g_first
      cau_div_stage #(.CW(CW), .DW(WW), .QW(W + 1), .SHIFT(W - k)) u_stage (
        .clk        (clk),
        .rst        (rst),
        .en         (dr[k]),
        .in_valid   (v4),
        .in_meta    (m4),
        .in_d       (d4),
        .in_rem_re  (rem4_re),
        .in_rem_im  (rem4_im),
        .in_q_re    ('0),
        .in_q_im    ('0),
        .out_valid  (dv[k]),
        .out_meta   (dm[k]),
        .out_d      (dd[k]),
        .out_rem_re (drr[k]),
        .out_rem_im (dri[k]),
        .out_q_re   (dqr[k]),
        .out_q_im   (dqi[k])
      );
    end else begin : g_next
      cau_div_stage #(.CW(CW), .DW(WW), .QW(W + 1), .SHIFT(W - k)) u_stage (
        .clk        (clk),
        .rst        (rst),
        .en         (dr[k]),
        .in_valid   (dv[k-1]),
        .in_meta    (dm[k-1]),
        .in_d       (dd[k-1]),
        .in_rem_re  (drr[k-1]),
        .in_rem_im  (dri[k-1]),
        .in_q_re    (dqr[k-1]),
        .in_q_im    (dqi[k-1]),
        .out_valid  (dv[k]),
        .out_meta   (dm[k]),
        .out_d      (dd[k]),
        .out_rem_re (drr[k]),
        .out_rem_im (dri[k]),
        .out_q_re   (dqr[k]),
        .out_q_im   (dqi[k])
      );
    end
    if (k == NDIV - 1) begin : g_up_last
      assign dr_up[k] = ro;
    end else begin : g_up_mid
      assign dr_up[k] = dr[k+1];
    end
    assign dr[k] = !dv[k] || dr_up[k];
  end

  // output register
  cau_pkg::meta_t        mf;
  cau_pkg::sat_t         q_re, q_im;
  cau_pkg::rsp_t         rsp_next;

  always_comb begin
    mf   = dm[NDIV-1];
    q_re = cau_pkg::sat_quot(dqr[NDIV-1], mf.neg_re, mf.ovf_re);
    q_im = cau_pkg::sat_quot(dqi[NDIV-1], mf.neg_im, mf.ovf_im);
    if (mf.is_div) begin
      rsp_next.res_re = q_re.val;
      rsp_next.res_im = q_im.val;
      rsp_next.status = (q_re.flag || q_im.flag) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end else begin
      rsp_next = mf.res;
    end
  end

  assign ro        = !rsp_valid || rsp_ready;
  assign r4        = !v4 || dr[0];
  assign r3        = !v3 || r4;
  assign r2        = !v2 || r3;
  assign r1        = !v1 || r2;
  assign req_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ro) begin
      rsp_valid <= dv[NDIV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ro) begin
      rsp <= rsp_next;
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == cau_pkg::ST_DZ |-> rsp.res_re == '0 && rsp.res_im == '0)
    else $error("divide-by-zero result not zero");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == cau_pkg::ST_SAT |->
      rsp.res_re == cau_pkg::VAL_MAX || rsp.res_re == cau_pkg::VAL_MIN ||
      rsp.res_im == cau_pkg::VAL_MAX || rsp.res_im == cau_pkg::VAL_MIN)
    else $error("saturated status without a limit value");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("pipeline blocked with empty output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result present after reset");

endmodule
